/* sv/lir_pkg.sv */
// Shared types, constants and helper functions for the linear-interpolation resampler.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package lir_pkg;

  // Output ring depth and the width of a ring slot index.
  localparam int unsigned RingDepth = 4096;
  localparam int unsigned RingIdxW  = 12;

  // Sample, phase and configuration port widths.
  localparam int unsigned SampleW  = 16;
  localparam int unsigned FracW    = 8;
  localparam int unsigned PhaseW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // One frame in phase units, the smallest usable step, and the 8-bit idle level.
  localparam int unsigned FracOne     = 256;
  localparam int unsigned MinStep     = 16;
  localparam int unsigned NarrowIdle  = 128;
  localparam int unsigned ResetStep   = 256;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgRateStep    = 8'd0,
    CfgLerpEnable  = 8'd1,
    CfgWideSamples = 8'd2,
    CfgStereo      = 8'd3
  } cfg_idx_e;

  // Configuration register file.
  typedef struct packed {
    logic [CfgDataW-1:0] rate_step;
    logic                lerp_enable;
    logic                wide_samples;
    logic                stereo;
  } cfg_t;

  // One output request from the sequencer: lane operands plus word control.
  typedef struct packed {
    logic                       valid;
    logic [RingIdxW-1:0]        ring_index;
    logic                       last_of_run;
    logic [FracW-1:0]           frac;
    logic signed [SampleW-1:0]  a_left;
    logic signed [SampleW-1:0]  b_left;
    logic signed [SampleW-1:0]  a_right;
    logic signed [SampleW-1:0]  b_right;
  } emit_t;

  // Bring a raw input sample to 16-bit signed: 8-bit samples are re-centered and shifted up.
  function automatic logic signed [SampleW-1:0] convert(input logic [SampleW-1:0] raw,
                                                        input logic wide);
    logic signed [SampleW-1:0] res;
    if (wide) begin
      res = raw;
    end else begin
      res = {~raw[7], raw[6:0], 8'h00};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* sv/lir_if.sv */
// Handshake interfaces for the resampler: input frames, output words and config writes.
// Widths come from lir_pkg.
`default_nettype none

// Input frame channel.
interface lir_in_if;
  logic                                valid;
  logic                                ready;
  logic                                first_of_chunk;
  logic                                last_of_chunk;
  logic signed [lir_pkg::SampleW-1:0]  left_raw;
  logic signed [lir_pkg::SampleW-1:0]  right_raw;
  logic [lir_pkg::TimeW-1:0]           painted_time;

  modport source(output valid, first_of_chunk, last_of_chunk, left_raw, right_raw,
                 painted_time, input ready);
  modport sink(input valid, first_of_chunk, last_of_chunk, left_raw, right_raw,
               painted_time, output ready);
endinterface

// Output word channel.
interface lir_out_if;
  logic                                valid;
  logic                                ready;
  logic [lir_pkg::RingIdxW-1:0]        ring_index;
  logic signed [lir_pkg::SampleW-1:0]  out_left;
  logic signed [lir_pkg::SampleW-1:0]  out_right;
  logic                                last_of_run;

  modport source(output valid, ring_index, out_left, out_right, last_of_run, input ready);
  modport sink(input valid, ring_index, out_left, out_right, last_of_run, output ready);
endinterface

// Configuration write channel.
interface lir_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lir_pkg::CfgIdxW-1:0]   index;
  logic [lir_pkg::CfgDataW-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/lir_lane.sv */
// One channel lane: picks the earlier sample or blends linearly toward the next one.
// Depends on lir_pkg for widths.
`default_nettype none

module lir_lane (
  input  logic signed [lir_pkg::SampleW-1:0] a_i,
  input  logic signed [lir_pkg::SampleW-1:0] b_i,
  input  logic [lir_pkg::FracW-1:0]          frac_i,
  input  logic                               lerp_i,
  output logic signed [lir_pkg::SampleW-1:0] y_o
);

  logic signed [lir_pkg::SampleW:0]                  diff;
  logic signed [lir_pkg::SampleW+lir_pkg::FracW+1:0] prod;
  logic signed [lir_pkg::SampleW+1:0]                step_amt;
  logic signed [lir_pkg::SampleW+1:0]                sum;

  // Scaled difference, floored to whole sample units by an arithmetic shift.
  always_comb begin
    diff     = $signed({b_i[lir_pkg::SampleW-1], b_i})
               - $signed({a_i[lir_pkg::SampleW-1], a_i});
    prod     = diff * $signed({1'b0, frac_i});
    step_amt = (lir_pkg::SampleW+2)'(prod >>> lir_pkg::FracW);
    sum      = $signed({{2{a_i[lir_pkg::SampleW-1]}}, a_i}) + step_amt;
    y_o      = lerp_i ? sum[lir_pkg::SampleW-1:0] : a_i;
  end

endmodule

`default_nettype wire

/* sv/lir_seq.sv */
// Phase sequencer: takes input frames, steps the output phase and drives both lanes.
// Depends on lir_pkg and the lir_in_if interface.
`default_nettype none

module lir_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lir_pkg::cfg_t        cfg_i,
  lir_in_if.sink               in_i,
  input  logic                 adv_i,
  output lir_pkg::emit_t       emit_o
);

  typedef enum logic [1:0] {
    SIdle,
    SRun,
    SFlush
  } state_e;

  state_e                              state_q;
  logic [lir_pkg::PhaseW-1:0]          phase_q;
  logic [lir_pkg::TimeW-1:0]           write_pos_q;
  logic                                have_prev_q;
  logic                                last_q;
  logic signed [lir_pkg::SampleW-1:0]  prev_l_q;
  logic signed [lir_pkg::SampleW-1:0]  prev_r_q;
  logic signed [lir_pkg::SampleW-1:0]  cur_l_q;
  logic signed [lir_pkg::SampleW-1:0]  cur_r_q;

  logic [lir_pkg::PhaseW-1:0]          step;
  logic [lir_pkg::PhaseW:0]            phase_nxt;
  logic [lir_pkg::PhaseW-1:0]          phase_rem;
  logic [lir_pkg::PhaseW-1:0]          skip_rem;
  logic                                run_done;
  logic                                flush_after_run;
  logic                                restart;
  logic signed [lir_pkg::SampleW-1:0]  in_l;
  logic signed [lir_pkg::SampleW-1:0]  in_r;
  logic signed [lir_pkg::SampleW-1:0]  dflt;

  // Step, phase lookahead and frame conversion.
  always_comb begin
    step = (cfg_i.rate_step < lir_pkg::PhaseW'(lir_pkg::MinStep))
           ? lir_pkg::PhaseW'(lir_pkg::MinStep) : cfg_i.rate_step;
    phase_nxt       = {1'b0, phase_q} + {1'b0, step};
    phase_rem       = lir_pkg::PhaseW'(phase_nxt - (lir_pkg::PhaseW+1)'(lir_pkg::FracOne));
    skip_rem        = phase_q - lir_pkg::PhaseW'(lir_pkg::FracOne);
    run_done        = phase_nxt >= (lir_pkg::PhaseW+1)'(lir_pkg::FracOne);
    flush_after_run = last_q && (phase_rem < lir_pkg::PhaseW'(lir_pkg::FracOne));
    restart         = in_i.first_of_chunk || !have_prev_q;
    in_l            = lir_pkg::convert(in_i.left_raw, cfg_i.wide_samples);
    in_r            = cfg_i.stereo ? lir_pkg::convert(in_i.right_raw, cfg_i.wide_samples)
                                   : in_l;
    dflt            = cfg_i.wide_samples ? '0 : lir_pkg::SampleW'(lir_pkg::NarrowIdle);
  end

  // Output request toward the lanes and the merge stage.
  always_comb begin
    emit_o.valid       = (state_q != SIdle);
    emit_o.ring_index  = lir_pkg::RingIdxW'(write_pos_q % lir_pkg::TimeW'(lir_pkg::RingDepth));
    emit_o.last_of_run = run_done && ((state_q == SFlush) || !flush_after_run);
    emit_o.frac        = phase_q[lir_pkg::FracW-1:0];
    emit_o.a_left      = prev_l_q;
    emit_o.a_right     = prev_r_q;
    emit_o.b_left      = (state_q == SFlush) ? dflt : cur_l_q;
    emit_o.b_right     = (state_q == SFlush) ? dflt : cur_r_q;
  end

  assign in_i.ready = (state_q == SIdle);

  // Sequencer state, phase and write position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      phase_q     <= '0;
      write_pos_q <= '0;
      have_prev_q <= 1'b0;
      last_q      <= 1'b0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      cur_l_q     <= '0;
      cur_r_q     <= '0;
    end else begin
      case (state_q)
        SIdle: begin
          if (in_i.valid) begin
            cur_l_q <= in_l;
            cur_r_q <= in_r;
            last_q  <= in_i.last_of_chunk;
            if (restart) begin
              // Chunk start: raise the write position and restart the phase.
              if (write_pos_q < in_i.painted_time) begin
                write_pos_q <= in_i.painted_time;
              end
              phase_q     <= '0;
              prev_l_q    <= in_l;
              prev_r_q    <= in_r;
              have_prev_q <= 1'b1;
              state_q     <= in_i.last_of_chunk ? SFlush : SIdle;
            end else if (phase_q < lir_pkg::PhaseW'(lir_pkg::FracOne)) begin
              state_q <= SRun;
            end else begin
              // No output falls before this frame.
              prev_l_q <= in_l;
              prev_r_q <= in_r;
              if (in_i.last_of_chunk) begin
                if (skip_rem < lir_pkg::PhaseW'(lir_pkg::FracOne)) begin
                  phase_q <= skip_rem;
                  state_q <= SFlush;
                end else begin
                  phase_q     <= '0;
                  have_prev_q <= 1'b0;
                end
              end else begin
                phase_q <= skip_rem;
              end
            end
          end
        end
        SRun: begin
          if (adv_i) begin
            write_pos_q <= write_pos_q + 1'b1;
            if (run_done) begin
              prev_l_q <= cur_l_q;
              prev_r_q <= cur_r_q;
              if (flush_after_run) begin
                phase_q <= phase_rem;
                state_q <= SFlush;
              end else if (last_q) begin
                phase_q     <= '0;
                have_prev_q <= 1'b0;
                state_q     <= SIdle;
              end else begin
                phase_q <= phase_rem;
                state_q <= SIdle;
              end
            end else begin
              phase_q <= phase_nxt[lir_pkg::PhaseW-1:0];
            end
          end
        end
        SFlush: begin
          if (adv_i) begin
            write_pos_q <= write_pos_q + 1'b1;
            if (run_done) begin
              phase_q     <= '0;
              have_prev_q <= 1'b0;
              state_q     <= SIdle;
            end else begin
              phase_q <= phase_nxt[lir_pkg::PhaseW-1:0];
            end
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/lir_merge.sv */
// Merge stage: combines the two lane results into one output word held in a register.
// Depends on lir_pkg and the lir_out_if interface.
`default_nettype none

module lir_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lir_pkg::emit_t                     emit_i,
  input  logic signed [lir_pkg::SampleW-1:0] lane_left_i,
  input  logic signed [lir_pkg::SampleW-1:0] lane_right_i,
  input  logic                               stereo_i,
  output logic                               adv_o,
  lir_out_if.source                          out_o
);

  logic                               valid_q;
  logic [lir_pkg::RingIdxW-1:0]       ring_q;
  logic signed [lir_pkg::SampleW-1:0] left_q;
  logic signed [lir_pkg::SampleW-1:0] right_q;
  logic                               last_q;

  // The register takes a new word when empty or when its word leaves.
  assign adv_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= emit_i.valid;
    end
  end

  // Word payload; mono copies the left lane to both channels.
  always_ff @(posedge clk_i) begin
    if (adv_o && emit_i.valid) begin
      ring_q  <= emit_i.ring_index;
      left_q  <= lane_left_i;
      right_q <= stereo_i ? lane_right_i : lane_left_i;
      last_q  <= emit_i.last_of_run;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.ring_index  = ring_q;
  assign out_o.out_left    = left_q;
  assign out_o.out_right   = right_q;
  assign out_o.last_of_run = last_q;

endmodule

`default_nettype wire

/* sv/linear_interp_audio_resampler.sv */
// Top level of the linear-interpolation audio resampler: config registers, sequencer,
// two channel lanes and the merge stage. Depends on lir_pkg, lir_if and all lir_* modules.
//
// Usage:
//   cfg_i  : register writes (index, data); always ready. Write only while the block is idle.
//   in_i   : one audio frame per word; ready only while the sequencer is idle.
//   out_o  : resampled stereo words with their ring slot; last_of_run marks the final
//            word caused by one input frame.
// Timing: a frame is accepted in the idle state, then the sequencer issues each output
//   word it causes in turn (up to 32 when stepping up in rate and flushing a chunk end).
//   The left and right lanes work in the same cycle, so one word leaves per cycle while
//   out_o.ready is high. Each issued word is captured in the merge stage's output register.
// Reset: registers return to step 256, no interpolation, 16-bit, stereo; phase and
//   write position clear and no frame is pending.
// Stall: while out_o.ready is low the output register holds its word and the sequencer
//   waits; a frame that causes no word can still be taken.
`default_nettype none

module linear_interp_audio_resampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  lir_cfg_if.sink     cfg_i,
  lir_in_if.sink      in_i,
  lir_out_if.source   out_o
);

  lir_pkg::cfg_t                       cfg_q;
  lir_pkg::emit_t                      emit;
  logic                                adv;
  logic signed [lir_pkg::SampleW-1:0]  lane_left;
  logic signed [lir_pkg::SampleW-1:0]  lane_right;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_step    <= lir_pkg::CfgDataW'(lir_pkg::ResetStep);
      cfg_q.lerp_enable  <= 1'b0;
      cfg_q.wide_samples <= 1'b1;
      cfg_q.stereo       <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        lir_pkg::CfgRateStep:    cfg_q.rate_step    <= cfg_i.data;
        lir_pkg::CfgLerpEnable:  cfg_q.lerp_enable  <= cfg_i.data[0];
        lir_pkg::CfgWideSamples: cfg_q.wide_samples <= cfg_i.data[0];
        lir_pkg::CfgStereo:      cfg_q.stereo       <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // Phase sequencer.
  lir_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .adv_i  (adv),
    .emit_o (emit)
  );

  // Left and right lanes.
  lir_lane u_lane_left (
    .a_i    (emit.a_left),
    .b_i    (emit.b_left),
    .frac_i (emit.frac),
    .lerp_i (cfg_q.lerp_enable),
    .y_o    (lane_left)
  );

  lir_lane u_lane_right (
    .a_i    (emit.a_right),
    .b_i    (emit.b_right),
    .frac_i (emit.frac),
    .lerp_i (cfg_q.lerp_enable),
    .y_o    (lane_right)
  );

  // Merge into the output register.
  lir_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_i       (emit),
    .lane_left_i  (lane_left),
    .lane_right_i (lane_right),
    .stereo_i     (cfg_q.stereo),
    .adv_o        (adv),
    .out_o        (out_o)
  );

  // A frame is only taken while no word is being issued.
  a_accept_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |-> !emit.valid)
    else $error("input word accepted while the sequencer issues output");

  // A stalled request stays in place.
  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid && !adv |=> emit.valid && $stable(emit.ring_index) && $stable(emit.frac))
    else $error("sequencer request changed during a stall");

  // Words within one run take consecutive ring slots.
  a_ring_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last_of_run |=>
      !out_o.valid ||
      out_o.ring_index == lir_pkg::RingIdxW'((32'($past(out_o.ring_index)) + 32'd1)
                                            % lir_pkg::RingDepth))
    else $error("ring slot did not advance by one within a run");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for linear_interp_audio_resampler: directed chunks, then random traffic.
// Predicts every output word from its own model of the block; needs lir_pkg and lir_if.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lir_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 64;

  typedef struct packed {
    logic [RingIdxW-1:0]       ring_index;
    logic signed [SampleW-1:0] out_left;
    logic signed [SampleW-1:0] out_right;
    logic                      last_of_run;
  } word_t;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  logic clk_i;
  logic rst_ni;
  logic sink_ready = 1'b0;

  lir_in_if  in_if ();
  lir_out_if out_if ();
  lir_cfg_if cfg_if ();

  linear_interp_audio_resampler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  assign out_if.ready = sink_ready;

  // Register copy, starting from the reset values.
  logic [CfgDataW-1:0] cfg_step   = CfgDataW'(ResetStep);
  logic                cfg_lerp   = 1'b0;
  logic                cfg_wide   = 1'b1;
  logic                cfg_stereo = 1'b1;

  // Resampler state copy.
  int          prev_l     = 0;
  int          prev_r     = 0;
  bit          have_prev  = 1'b0;
  int unsigned phase_acc  = 0;
  int unsigned wpos       = 0;
  word_t       held_word;
  bit          held_valid = 1'b0;

  word_t       expected_words[$];
  int          errors     = 0;
  int          words_seen = 0;
  int          send_pct   = 0;
  int          recv_pct   = 0;
  longint      cycles     = 0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Convert a raw sample according to the current width setting.
  function automatic int to_sample(logic [SampleW-1:0] raw);
    if (cfg_wide) begin
      return int'($signed(raw));
    end
    return (int'(raw[7:0]) - int'(NarrowIdle)) * int'(FracOne);
  endfunction

  // Blend from a toward b by the fractional part of ph, with floor rounding.
  function automatic int mix(int a, int b, int unsigned ph);
    int d;
    if (!cfg_lerp) begin
      return a;
    end
    d = (b - a) * int'(ph % FracOne);
    return a + (d >>> FracW);
  endfunction

  // Queue a word; the newest one is held back so that it can be marked as the last of its run.
  function automatic void emit_word(int l, int r);
    if (held_valid) begin
      expected_words.push_back(held_word);
    end
    held_word.ring_index  = RingIdxW'(wpos % RingDepth);
    held_word.out_left    = l[SampleW-1:0];
    held_word.out_right   = r[SampleW-1:0];
    held_word.last_of_run = 1'b0;
    held_valid = 1'b1;
    wpos = wpos + 1;
  endfunction

  // Work out every word that one accepted frame causes.
  function automatic void predict_frame(logic first, logic last, logic [SampleW-1:0] lraw,
                                        logic [SampleW-1:0] rraw, logic [TimeW-1:0] painted);
    int unsigned stp;
    int cur_l;
    int cur_r;
    int l;
    int idle_level;
    stp = (cfg_step < MinStep) ? MinStep : int'(cfg_step);
    cur_l = to_sample(lraw);
    cur_r = cfg_stereo ? to_sample(rraw) : cur_l;
    held_valid = 1'b0;
    if (first || !have_prev) begin
      if (wpos < painted) begin
        wpos = painted;
      end
      phase_acc = 0;
    end else begin
      while (phase_acc < FracOne) begin
        l = mix(prev_l, cur_l, phase_acc);
        emit_word(l, cfg_stereo ? mix(prev_r, cur_r, phase_acc) : l);
        phase_acc = phase_acc + stp;
      end
      phase_acc = phase_acc - FracOne;
    end
    prev_l = cur_l;
    prev_r = cur_r;
    have_prev = 1'b1;
    // A chunk end flushes toward the idle level of the current width.
    if (last) begin
      idle_level = cfg_wide ? 0 : int'(NarrowIdle);
      while (phase_acc < FracOne) begin
        l = mix(cur_l, idle_level, phase_acc);
        emit_word(l, cfg_stereo ? mix(cur_r, idle_level, phase_acc) : l);
        phase_acc = phase_acc + stp;
      end
      phase_acc = 0;
      have_prev = 1'b0;
    end
    if (held_valid) begin
      held_word.last_of_run = 1'b1;
      expected_words.push_back(held_word);
      held_valid = 1'b0;
    end
  endfunction

  // Output checks, register tracking and prediction, all sampled at the clock edge.
  always @(posedge clk_i) begin : monitor
    word_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        words_seen = words_seen + 1;
        if (expected_words.size() == 0) begin
          $error("unexpected word: ring_index %0d out_left %0d out_right %0d",
                 out_if.ring_index, out_if.out_left, out_if.out_right);
          errors = errors + 1;
        end else begin
          want = expected_words.pop_front();
          if (out_if.ring_index !== want.ring_index) begin
            $error("ring_index: expected %0d, actual %0d", want.ring_index, out_if.ring_index);
            errors = errors + 1;
          end
          if (out_if.out_left !== want.out_left) begin
            $error("out_left: expected %0d, actual %0d", want.out_left, out_if.out_left);
            errors = errors + 1;
          end
          if (out_if.out_right !== want.out_right) begin
            $error("out_right: expected %0d, actual %0d", want.out_right, out_if.out_right);
            errors = errors + 1;
          end
          if (out_if.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                   out_if.last_of_run);
            errors = errors + 1;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CfgRateStep:    cfg_step   = cfg_if.data;
          CfgLerpEnable:  cfg_lerp   = cfg_if.data[0];
          CfgWideSamples: cfg_wide   = cfg_if.data[0];
          CfgStereo:      cfg_stereo = cfg_if.data[0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        predict_frame(in_if.first_of_chunk, in_if.last_of_chunk, in_if.left_raw,
                      in_if.right_raw, in_if.painted_time);
      end
    end
  end

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    sink_ready <= ($urandom_range(0, 99) >= recv_pct);
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void set_idle(idle_mode_e mode);
    case (mode)
      IdleNone:     begin send_pct = 0;  recv_pct = 0;  end
      IdleSender:   begin send_pct = 51; recv_pct = 0;  end
      IdleReceiver: begin send_pct = 0;  recv_pct = 51; end
      default:      begin send_pct = 30; recv_pct = 30; end
    endcase
  endfunction

  // Send one frame word; valid stays high so that a following frame can go back to back.
  task automatic send_frame(logic first, logic last, logic [SampleW-1:0] lraw,
                            logic [SampleW-1:0] rraw, logic [TimeW-1:0] painted);
    while ($urandom_range(0, 99) < send_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.first_of_chunk <= first;
    in_if.last_of_chunk  <= last;
    in_if.left_raw       <= lraw;
    in_if.right_raw      <= rraw;
    in_if.painted_time   <= painted;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Stop sending and wait until every predicted word has come and the block has settled.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic cfg_close();
    cfg_if.valid <= 1'b0;
  endtask

  // Write all four registers; unused data bits of the flag registers carry random values.
  task automatic set_config(logic [CfgDataW-1:0] step, bit lerp, bit wide, bit stereo);
    cfg_write(CfgRateStep, step);
    cfg_write(CfgLerpEnable, CfgDataW'({$urandom, lerp}));
    cfg_write(CfgWideSamples, CfgDataW'({$urandom, wide}));
    cfg_write(CfgStereo, CfgDataW'({$urandom, stereo}));
    cfg_close();
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 16'h8000;
    end else if (r == 1) begin
      return 16'h7fff;
    end
    return SampleW'($urandom);
  endfunction

  // Painted time: mostly a little ahead of the write position, sometimes anywhere or behind.
  function automatic logic [TimeW-1:0] pick_painted();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      return wpos + $urandom_range(0, 40);
    end else if (r < 9) begin
      return $urandom;
    end
    return wpos - $urandom_range(1, 100);
  endfunction

  // Reset register values: plain pick at unit step, 16-bit stereo, extreme samples.
  task automatic test_reset_defaults();
    send_frame(1'b1, 1'b0, 16'h7fff, 16'h8000, 32'd100);
    send_frame(1'b0, 1'b0, 16'h8000, 16'h7fff, 32'd0);
    send_frame(1'b0, 1'b0, 16'h0000, 16'hffff, 32'hffff_ffff);
    send_frame(1'b0, 1'b1, 16'h1234, 16'hedcb, 32'd0);
    wait_idle();
  endtask

  // Smallest step with interpolation: a frame pair gives the most words per frame.
  task automatic test_fast_upsample();
    set_config(CfgDataW'(MinStep), 1'b1, 1'b1, 1'b1);
    send_frame(1'b1, 1'b0, 16'h8000, 16'h7fff, 32'd0);
    send_frame(1'b0, 1'b1, 16'h7fff, 16'h8000, 32'd0);
    wait_idle();
  endtask

  // Steps below the minimum behave as the minimum; includes a single-frame chunk.
  task automatic test_small_step();
    set_config(16'd0, 1'b1, 1'b1, 1'b1);
    send_frame(1'b1, 1'b1, 16'h4000, 16'hc000, pick_painted());
    wait_idle();
    set_config(CfgDataW'(MinStep - 1), 1'b1, 1'b1, 1'b0);
    send_frame(1'b1, 1'b0, 16'h0001, 16'h5555, pick_painted());
    send_frame(1'b0, 1'b1, 16'hfffe, 16'haaaa, pick_painted());
    wait_idle();
  endtask

  // 8-bit mono: low byte extremes, upper bits ignored, flush toward the narrow idle level.
  task automatic test_narrow_mono();
    set_config(16'd200, 1'b1, 1'b0, 1'b0);
    send_frame(1'b1, 1'b0, 16'hff00, 16'h1234, pick_painted());
    send_frame(1'b0, 1'b0, 16'h00ff, 16'hffff, pick_painted());
    send_frame(1'b0, 1'b1, 16'h0080, 16'h0000, pick_painted());
    wait_idle();
  endtask

  // Frame with no open chunk, restart inside a chunk, stale painted time, 32-bit wrap.
  task automatic test_chunk_edges();
    set_config(16'd384, 1'b1, 1'b1, 1'b1);
    send_frame(1'b0, 1'b0, 16'h3000, 16'hd000, wpos + 32'd7);
    send_frame(1'b1, 1'b0, 16'h9000, 16'h6000, wpos - 32'd50);
    send_frame(1'b0, 1'b0, 16'h2000, 16'he000, 32'd0);
    send_frame(1'b1, 1'b1, 16'h7fff, 16'h8000, 32'hffff_fffe);
    send_frame(1'b0, 1'b1, 16'h8000, 16'h7fff, 32'd3);
    wait_idle();
  endtask

  // Largest step: frames mostly pass without any word.
  task automatic test_big_step();
    set_config(16'hffff, 1'b0, 1'b1, 1'b1);
    send_frame(1'b1, 1'b0, 16'h1111, 16'h2222, pick_painted());
    send_frame(1'b0, 1'b0, 16'h3333, 16'h4444, pick_painted());
    send_frame(1'b0, 1'b0, 16'h5555, 16'h6666, pick_painted());
    send_frame(1'b0, 1'b1, 16'h7777, 16'h8888, pick_painted());
    wait_idle();
  endtask

  // Width and channel changes while a chunk is open; an unused index changes nothing.
  task automatic test_mode_change();
    set_config(16'd128, 1'b1, 1'b1, 1'b1);
    send_frame(1'b1, 1'b0, 16'h8000, 16'h7fff, pick_painted());
    wait_idle();
    cfg_write(CfgWideSamples, 16'h0000);
    cfg_write(CfgStereo, 16'hfffe);
    cfg_write(CfgIdxW'(8'hf0), 16'hffff);
    cfg_close();
    send_frame(1'b0, 1'b0, 16'h00ff, 16'h0000, pick_painted());
    wait_idle();
    set_config(16'd128, 1'b0, 1'b1, 1'b1);
    send_frame(1'b0, 1'b1, 16'h7fff, 16'h8000, pick_painted());
    wait_idle();
  endtask

  // Random chunks under each idling pattern with a fresh random setting per phase.
  task automatic test_random_traffic();
    int items;
    int words_start;
    int len;
    int r;
    logic [CfgDataW-1:0] step;
    for (int mode = IdleNone; mode <= IdleBoth; mode++) begin
      set_idle(idle_mode_e'(mode));
      r = $urandom_range(0, 9);
      if (r == 0) begin
        step = CfgDataW'($urandom_range(0, MinStep - 1));
      end else if (r == 1) begin
        step = 16'hffff;
      end else if (r == 2) begin
        step = CfgDataW'($urandom_range(257, 4000));
      end else begin
        step = CfgDataW'($urandom_range(MinStep, 400));
      end
      set_config(step, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
      items = 0;
      words_start = words_seen;
      while (items < 50 || words_seen - words_start < 30) begin
        if ($urandom_range(0, 99) < 85) begin
          // Well-formed chunk, usually short.
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 5);
          for (int i = 0; i < len; i++) begin
            send_frame(i == 0, i == len - 1, pick_sample(), pick_sample(), pick_painted());
            items++;
            if (i != len - 1 && $urandom_range(0, 99) < 8) begin
              wait_idle();
              cfg_write(CfgWideSamples, CfgDataW'($urandom));
              cfg_write(CfgStereo, CfgDataW'($urandom));
              cfg_write(CfgLerpEnable, CfgDataW'($urandom));
              cfg_close();
            end
          end
        end else begin
          // Stray frame with random chunk flags.
          send_frame($urandom_range(0, 1), $urandom_range(0, 1), pick_sample(), pick_sample(),
                     pick_painted());
          items++;
        end
        if ($urandom_range(0, 99) < 15) begin
          wait_idle();
        end
      end
      wait_idle();
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.first_of_chunk <= 1'b0;
    in_if.last_of_chunk  <= 1'b0;
    in_if.left_raw       <= '0;
    in_if.right_raw      <= '0;
    in_if.painted_time   <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= '0;
    cfg_if.data          <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idle(IdleNone);
    test_reset_defaults();
    test_fast_upsample();
    test_small_step();
    test_narrow_mono();
    test_chunk_edges();
    test_big_step();
    test_mode_change();
    test_random_traffic();
    wait_idle();
    if (errors == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/lir_pkg.sv
sv/lir_if.sv
sv/lir_lane.sv
sv/lir_seq.sv
sv/lir_merge.sv
sv/linear_interp_audio_resampler.sv
bench/tb_top.sv
